// ----- sv/coordinate_seeded_lcg_random_core_assert.svh -----
// Assertion macros for the coordinate-seeded LCG random core
`ifndef COORDINATE_SEEDED_LCG_RANDOM_CORE_ASSERT_SVH
`define COORDINATE_SEEDED_LCG_RANDOM_CORE_ASSERT_SVH

// same-cycle implication
`define CSLR_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication
`define CSLR_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- sv/cslr_pkg.sv -----
package cslr_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int COORD_W    = 32;
    localparam int VALUE_W    = 31;
    localparam int ID_W       = 8;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 128;
    localparam int M_TDATA_W  = 32;
    localparam int DRAW_SHIFT = 24;
    localparam int DRAW_Q_W   = WORD_W - DRAW_SHIFT;
    localparam int REM_CNT_W  = $clog2(DRAW_Q_W);
    localparam int PICK_COUNT = 4;

    localparam logic [WORD_W-1:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [WORD_W-1:0] LCG_INC = 64'd1442695040888963407;

    localparam logic [REM_CNT_W-1:0] REM_LAST = REM_CNT_W'(DRAW_Q_W - 1);

    localparam logic [ACTION_W-1:0] ACT_SEED = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DRAW = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WORLD_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_SALT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_M1_GO,
        ST_M1_WAIT,
        ST_M2_GO,
        ST_M2_WAIT,
        ST_REM_GO,
        ST_REM_WAIT,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        JOB_SALT,
        JOB_LAYER,
        JOB_CELL,
        JOB_DRAW,
        JOB_PICK
    } job_t;

endpackage

// ----- sv/cslr_mul64.sv -----
module cslr_mul64
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cslr_pkg::WORD_W-1:0]  a,
    input  logic [cslr_pkg::WORD_W-1:0]  b,
    output logic                         done,
    output logic [cslr_pkg::WORD_W-1:0]  p
);

    localparam int HW = cslr_pkg::HALF_W;
    localparam int WW = cslr_pkg::WORD_W;

    logic          busy_reg;
    logic [1:0]    cnt_reg;
    logic          done_reg;
    logic [WW-1:0] a_reg;
    logic [WW-1:0] b_reg;
    logic [WW-1:0] prod_reg;
    logic [WW-1:0] acc_reg;

    logic [HW-1:0] op_x;
    logic [HW-1:0] op_y;
    logic [WW-1:0] mult;
    logic [WW-1:0] add_term;

    // low 64 bits: lo*lo + ((lo*hi + hi*lo) << 32), one 32x32 product a cycle
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                op_x = a_reg[HW-1:0];
                op_y = b_reg[HW-1:0];
            end
            2'd1:
            begin
                op_x = a_reg[HW-1:0];
                op_y = b_reg[WW-1:HW];
            end
            default:
            begin
                op_x = a_reg[WW-1:HW];
                op_y = b_reg[HW-1:0];
            end
        endcase
        mult     = WW'(op_x) * WW'(op_y);
        add_term = (cnt_reg == 2'd1) ? prod_reg : {prod_reg[HW-1:0], {HW{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 2'd3)
            begin
                prod_reg <= mult;
            end
            if (cnt_reg != 2'd0)
            begin
                acc_reg <= acc_reg + add_term;
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

// ----- sv/cslr_rem.sv -----
module cslr_rem
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [cslr_pkg::DRAW_Q_W-1:0]   dividend,
    input  logic [cslr_pkg::VALUE_W-1:0]    divisor,
    output logic                            done,
    output logic [cslr_pkg::VALUE_W-1:0]    remainder
);

    localparam int DW = cslr_pkg::DRAW_Q_W;
    localparam int VW = cslr_pkg::VALUE_W;

    logic                           busy_reg;
    logic                           done_reg;
    logic [cslr_pkg::REM_CNT_W-1:0] cnt_reg;
    logic [DW-1:0]                  dvd_reg;
    logic [VW-1:0]                  dsr_reg;
    logic [VW:0]                    rem_reg;

    logic [VW:0] rem_sh;
    logic [VW:0] diff;
    logic        ge;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_sh = {rem_reg[VW-1:0], dvd_reg[DW-1]};
        diff   = rem_sh - {1'b0, dsr_reg};
        ge     = rem_sh >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + cslr_pkg::REM_CNT_W'(1);
                if (cnt_reg == cslr_pkg::REM_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : rem_sh;
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[VW-1:0];

endmodule

// ----- sv/coordinate_seeded_lcg_random_core.sv -----
// Each mix s*(s*MUL+INC)+addend runs on the shared multiplier, one 32x32 product at a time.
// Seed (action 0): mixes x and y into the cell state, no result. Draw (action 1): the 40-step
// remainder unit, then one mix, then the result. Action 2 with a plurality id goes straight
// to the result state; otherwise as a draw. One transaction in flight; m_tready stalls hold
// the result state. After rst_n (asynchronous, active low) and each config write to index 0
// or 1 the seeds are re-derived, ports not ready.
`include "coordinate_seeded_lcg_random_core_assert.svh"

module coordinate_seeded_lcg_random_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_x[31:0], cell_y[63:32], bound[94:64], id_a[102:95], id_b[110:103],
    // id_c[118:111], id_d[126:119], zero pad
    input  logic [cslr_pkg::S_TDATA_W-1:0]     s_tdata,
    // action[1:0]
    input  logic [cslr_pkg::ACTION_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // value[30:0], zero pad
    output logic [cslr_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cslr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cslr_pkg::WORD_W-1:0]        cfg_data
);

    localparam int WW = cslr_pkg::WORD_W;
    localparam int VW = cslr_pkg::VALUE_W;
    localparam int IW = cslr_pkg::ID_W;
    localparam int CW = cslr_pkg::COORD_W;

    cslr_pkg::state_t state_reg, state_next;
    cslr_pkg::job_t   job_reg, job_next;

    logic [1:0]    mix_idx_reg, mix_idx_next;
    logic [WW-1:0] acc_reg, acc_next;
    logic [WW-1:0] tmp_reg, tmp_next;
    logic [WW-1:0] world_seed_reg, world_seed_next;
    logic [WW-1:0] layer_salt_reg, layer_salt_next;
    logic [WW-1:0] mixed_salt_reg, mixed_salt_next;
    logic [WW-1:0] layer_seed_reg, layer_seed_next;
    logic [WW-1:0] cell_state_reg, cell_state_next;
    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] y_reg, y_next;
    logic [VW-1:0] bound_reg, bound_next;
    logic [IW-1:0] ids_reg [cslr_pkg::PICK_COUNT];
    logic [IW-1:0] ids_next [cslr_pkg::PICK_COUNT];
    logic [VW-1:0] result_reg, result_next;
    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] out_value_reg, out_value_next;

    logic                  in_accept;
    logic                  cfg_accept;
    logic                  cfg_hit;
    logic                  out_free;
    logic [1:0]            mix_last;
    logic                  mix_end;
    logic [WW-1:0]         addend;
    logic [WW-1:0]         mix_sum;
    logic                  maj_hit;
    logic [IW-1:0]         maj_val;
    logic [IW-1:0]         in_id [cslr_pkg::PICK_COUNT];

    logic                          mul_start;
    logic [WW-1:0]                 mul_b;
    logic                          mul_done;
    logic [WW-1:0]                 mul_p;
    logic                          rem_start;
    logic                          rem_done;
    logic [VW-1:0]                 rem_r;
    logic [cslr_pkg::DRAW_Q_W-1:0] draw_q;
    logic [cslr_pkg::DRAW_Q_W-1:0] draw_mag;
    logic [VW-1:0]                 draw_r;

    cslr_mul64 u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (acc_reg),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    cslr_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (draw_mag),
        .divisor   (bound_reg),
        .done      (rem_done),
        .remainder (rem_r)
    );

    assign in_accept  = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_hit    = (cfg_index == cslr_pkg::CFG_WORLD_SEED) ||
                        (cfg_index == cslr_pkg::CFG_LAYER_SALT);
    assign out_free   = !out_valid_reg || m_tready;

    assign in_id[0] = s_tdata[102:95];
    assign in_id[1] = s_tdata[110:103];
    assign in_id[2] = s_tdata[118:111];
    assign in_id[3] = s_tdata[126:119];

    // plurality id of the four: three or more alike, or one pair with the other two unlike; fixed priority
    always_comb
    begin
        maj_hit = 1'b1;
        maj_val = in_id[0];
        if (in_id[1] == in_id[2] && in_id[2] == in_id[3])
            maj_val = in_id[1];
        else if (in_id[0] == in_id[1] && in_id[0] == in_id[2])
            maj_val = in_id[0];
        else if (in_id[0] == in_id[1] && in_id[0] == in_id[3])
            maj_val = in_id[0];
        else if (in_id[0] == in_id[2] && in_id[0] == in_id[3])
            maj_val = in_id[0];
        else if (in_id[0] == in_id[1] && in_id[2] != in_id[3])
            maj_val = in_id[0];
        else if (in_id[0] == in_id[2] && in_id[1] != in_id[3])
            maj_val = in_id[0];
        else if (in_id[0] == in_id[3] && in_id[1] != in_id[2])
            maj_val = in_id[0];
        else if (in_id[1] == in_id[2] && in_id[0] != in_id[3])
            maj_val = in_id[1];
        else if (in_id[1] == in_id[3] && in_id[0] != in_id[2])
            maj_val = in_id[1];
        else if (in_id[2] == in_id[3] && in_id[0] != in_id[1])
            maj_val = in_id[2];
        else
            maj_hit = 1'b0;
    end

    // draw: remainder of |state >>> 24| by bound, mapped to bound - r for negative state; zero for bound 0
    always_comb
    begin
        draw_q   = cslr_pkg::DRAW_Q_W'($signed(cell_state_reg) >>> cslr_pkg::DRAW_SHIFT);
        draw_mag = cell_state_reg[WW-1] ? (~draw_q + cslr_pkg::DRAW_Q_W'(1)) : draw_q;
        if (bound_reg == '0)
            draw_r = '0;
        else if (cell_state_reg[WW-1] && rem_r != '0)
            draw_r = bound_reg - rem_r;
        else
            draw_r = rem_r;
    end

    always_comb
    begin
        case (job_reg)
            cslr_pkg::JOB_SALT:
            begin
                addend   = layer_salt_reg;
                mix_last = 2'd2;
            end
            cslr_pkg::JOB_LAYER:
            begin
                addend   = mixed_salt_reg;
                mix_last = 2'd2;
            end
            cslr_pkg::JOB_CELL:
            begin
                addend   = mix_idx_reg[0] ? {{(WW-CW){y_reg[CW-1]}}, y_reg}
                                          : {{(WW-CW){x_reg[CW-1]}}, x_reg};
                mix_last = 2'd3;
            end
            default:
            begin
                addend   = layer_seed_reg;
                mix_last = 2'd0;
            end
        endcase
        mix_end = (mix_idx_reg == mix_last);
        mix_sum = mul_p + addend;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cslr_pkg::ST_IDLE:
            begin
                if (cfg_accept)
                begin
                    if (cfg_hit)
                        state_next = cslr_pkg::ST_M1_GO;
                end
                else if (in_accept)
                begin
                    case (s_tuser)
                        cslr_pkg::ACT_SEED: state_next = cslr_pkg::ST_M1_GO;
                        cslr_pkg::ACT_DRAW: state_next = cslr_pkg::ST_REM_GO;
                        cslr_pkg::ACT_PICK:
                            state_next = maj_hit ? cslr_pkg::ST_RESULT : cslr_pkg::ST_REM_GO;
                        default:            state_next = cslr_pkg::ST_IDLE;
                    endcase
                end
            end
            cslr_pkg::ST_M1_GO:
                state_next = cslr_pkg::ST_M1_WAIT;
            cslr_pkg::ST_M1_WAIT:
            begin
                if (mul_done)
                    state_next = cslr_pkg::ST_M2_GO;
            end
            cslr_pkg::ST_M2_GO:
                state_next = cslr_pkg::ST_M2_WAIT;
            cslr_pkg::ST_M2_WAIT:
            begin
                if (mul_done)
                begin
                    if (!mix_end)
                        state_next = cslr_pkg::ST_M1_GO;
                    else
                    begin
                        case (job_reg)
                            cslr_pkg::JOB_SALT:  state_next = cslr_pkg::ST_M1_GO;
                            cslr_pkg::JOB_LAYER: state_next = cslr_pkg::ST_IDLE;
                            cslr_pkg::JOB_CELL:  state_next = cslr_pkg::ST_IDLE;
                            default:             state_next = cslr_pkg::ST_RESULT;
                        endcase
                    end
                end
            end
            cslr_pkg::ST_REM_GO:
                state_next = cslr_pkg::ST_REM_WAIT;
            cslr_pkg::ST_REM_WAIT:
            begin
                if (rem_done)
                    state_next = cslr_pkg::ST_M1_GO;
            end
            cslr_pkg::ST_RESULT:
            begin
                if (out_free)
                    state_next = cslr_pkg::ST_IDLE;
            end
            default:
                state_next = cslr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cfg_ready = (state_reg == cslr_pkg::ST_IDLE);
        s_tready  = (state_reg == cslr_pkg::ST_IDLE) && !cfg_valid;
        mul_start = (state_reg == cslr_pkg::ST_M1_GO) || (state_reg == cslr_pkg::ST_M2_GO);
        mul_b     = (state_reg == cslr_pkg::ST_M1_GO) ? cslr_pkg::LCG_MUL : tmp_reg;
        rem_start = (state_reg == cslr_pkg::ST_REM_GO);
        m_tvalid  = out_valid_reg;
        m_tdata   = {{(cslr_pkg::M_TDATA_W-VW){1'b0}}, out_value_reg};
    end

    // datapath
    always_comb
    begin
        job_next        = job_reg;
        mix_idx_next    = mix_idx_reg;
        acc_next        = acc_reg;
        tmp_next        = tmp_reg;
        world_seed_next = world_seed_reg;
        layer_salt_next = layer_salt_reg;
        mixed_salt_next = mixed_salt_reg;
        layer_seed_next = layer_seed_reg;
        cell_state_next = cell_state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        bound_next      = bound_reg;
        ids_next        = ids_reg;
        result_next     = result_reg;
        out_value_next  = out_value_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        case (state_reg)
            cslr_pkg::ST_IDLE:
            begin
                if (cfg_accept)
                begin
                    job_next     = cslr_pkg::JOB_SALT;
                    mix_idx_next = 2'd0;
                    acc_next     = layer_salt_reg;
                    if (cfg_index == cslr_pkg::CFG_WORLD_SEED)
                        world_seed_next = cfg_data;
                    if (cfg_index == cslr_pkg::CFG_LAYER_SALT)
                    begin
                        layer_salt_next = cfg_data;
                        acc_next        = cfg_data;
                    end
                end
                else if (in_accept)
                begin
                    x_next       = s_tdata[31:0];
                    y_next       = s_tdata[63:32];
                    bound_next   = s_tdata[94:64];
                    ids_next     = in_id;
                    mix_idx_next = 2'd0;
                    acc_next     = cell_state_reg;
                    case (s_tuser)
                        cslr_pkg::ACT_SEED:
                        begin
                            job_next = cslr_pkg::JOB_CELL;
                            acc_next = layer_seed_reg;
                        end
                        cslr_pkg::ACT_DRAW:
                            job_next = cslr_pkg::JOB_DRAW;
                        default:
                        begin
                            job_next    = cslr_pkg::JOB_PICK;
                            bound_next  = VW'(cslr_pkg::PICK_COUNT);
                            result_next = VW'(maj_val);
                        end
                    endcase
                end
            end
            cslr_pkg::ST_M1_WAIT:
            begin
                if (mul_done)
                    tmp_next = mul_p + cslr_pkg::LCG_INC;
            end
            cslr_pkg::ST_M2_WAIT:
            begin
                if (mul_done)
                begin
                    if (!mix_end)
                    begin
                        acc_next     = mix_sum;
                        mix_idx_next = mix_idx_reg + 2'd1;
                    end
                    else
                    begin
                        case (job_reg)
                            cslr_pkg::JOB_SALT:
                            begin
                                mixed_salt_next = mix_sum;
                                acc_next        = world_seed_reg;
                                job_next        = cslr_pkg::JOB_LAYER;
                                mix_idx_next    = 2'd0;
                            end
                            cslr_pkg::JOB_LAYER:
                                layer_seed_next = mix_sum;
                            default:
                                cell_state_next = mix_sum;
                        endcase
                    end
                end
            end
            cslr_pkg::ST_REM_WAIT:
            begin
                if (rem_done)
                begin
                    if (job_reg == cslr_pkg::JOB_PICK)
                        result_next = VW'(ids_reg[draw_r[1:0]]);
                    else
                        result_next = draw_r;
                end
            end
            cslr_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_value_next = result_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cslr_pkg::ST_M1_GO;
            job_reg        <= cslr_pkg::JOB_SALT;
            mix_idx_reg    <= 2'd0;
            acc_reg        <= '0;
            world_seed_reg <= '0;
            layer_salt_reg <= '0;
            cell_state_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            mix_idx_reg    <= mix_idx_next;
            acc_reg        <= acc_next;
            world_seed_reg <= world_seed_next;
            layer_salt_reg <= layer_salt_next;
            cell_state_reg <= cell_state_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg        <= tmp_next;
        mixed_salt_reg <= mixed_salt_next;
        layer_seed_reg <= layer_seed_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        bound_reg      <= bound_next;
        ids_reg        <= ids_next;
        result_reg     <= result_next;
        out_value_reg  <= out_value_next;
    end

    `CSLR_ASSERT_NOW(a_cfg_excl, clk, rst_n, cfg_accept, !s_tready,
        "config and item in same cycle")
    `CSLR_ASSERT_NOW(a_mul_done, clk, rst_n, mul_done,
        (state_reg == cslr_pkg::ST_M1_WAIT || state_reg == cslr_pkg::ST_M2_WAIT),
        "multiplier done outside a wait state")
    `CSLR_ASSERT_NOW(a_rem_done, clk, rst_n, rem_done, state_reg == cslr_pkg::ST_REM_WAIT,
        "remainder done outside its wait state")
    `CSLR_ASSERT_NEXT(a_draw_go, clk, rst_n, in_accept && s_tuser == cslr_pkg::ACT_DRAW,
        state_reg == cslr_pkg::ST_REM_GO, "draw did not start remainder unit")

endmodule
